### rtl/knn_graph_hop_distance_unit_assert.svh
// assertion macros used by the checker file
`ifndef KNN_GRAPH_HOP_DISTANCE_UNIT_ASSERT_SVH
`define KNN_GRAPH_HOP_DISTANCE_UNIT_ASSERT_SVH

// same-cycle implication, disabled while rst is low
`define KHD_ASSERT_NOW(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!(rst)) (a) |-> (b)) \
    else $error("assertion failed: a |-> b");

// next-cycle implication, disabled while rst is low
`define KHD_ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!(rst)) (a) |=> (b)) \
    else $error("assertion failed: a |=> b");

`endif

### rtl/khd_pkg.sv
// shared types and constants of the hop distance unit
`timescale 1ns / 1ps
`default_nettype none

package khd_pkg;

  localparam int ROW_W   = 6;
  localparam int DIN_W   = 32;
  localparam int HOP_W   = 7;
  localparam int NC_W    = 7;
  localparam int MC_W    = 6;
  localparam int CFG_W   = 7;

  localparam logic [HOP_W-1:0] HOP_NONE = 7'h7F;
  localparam logic [5:0]       HOP_MAX  = 6'd63;

  localparam logic CFG_NODE_COUNT   = 1'b0;
  localparam logic CFG_MAX_CHILDREN = 1'b1;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [4:0] {
    OP_NOP, OP_B_INIT, OP_R_ROW, OP_R_RD, OP_R_END, OP_T_ROW, OP_C_RD, OP_C_END,
    OP_S_RD, OP_S_K, OP_S_JEND, OP_A_RD, OP_A_END, OP_W_INIT, OP_W_POP, OP_W_V,
    OP_O_RD, OP_O_LD
  } op_t;

  typedef struct packed {
    op_t  op;
    logic in_take;
  } cmd_t;

  typedef struct packed {
    logic in_pending;
    logic is_query;
    logic q_ok;
    logic graph_ready;
    logic i_last;
    logic j_last;
    logic k_last;
    logic cand_gt;
    logic q_empty;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

### rtl/khd_datapath.sv
// datapath: distance, adjacency, queue and hop memories with counters
`timescale 1ns / 1ps
`default_nettype none

module khd_datapath #(
  parameter int MAX_NODES = 64,
  parameter int DIST_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire khd_pkg::cmd_t          cmd,
  output khd_pkg::status_t            st,
  input  wire logic                   in_tvalid,
  input  wire logic [47:0]            in_tdata,
  input  wire logic                   in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [15:0]                 out_tdata,
  output logic                        out_tlast,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_index,
  input  wire logic [khd_pkg::CFG_W-1:0] cfg_data
);

  localparam int LIM    = (MAX_NODES < 64) ? MAX_NODES : 64;
  localparam int IW     = $clog2(LIM);
  localparam int CW     = IW + 1;
  localparam int DDEPTH = 2 ** (2 * IW);

  logic [khd_pkg::ROW_W-1:0] in_row, in_col;
  logic [khd_pkg::DIN_W-1:0] in_dist;
  logic [63:0]               dist_ext;
  logic [DIST_BITS-1:0]      dv;

  assign in_row   = in_tdata[5:0];
  assign in_col   = in_tdata[11:6];
  assign in_dist  = in_tdata[43:12];
  assign dist_ext = {32'd0, in_dist};
  assign dv       = dist_ext[DIST_BITS-1:0];

  logic [khd_pkg::NC_W-1:0] n_r;
  logic [khd_pkg::MC_W-1:0] mc_r;
  logic                     gready_r;
  logic [khd_pkg::NC_W-1:0] n_act, n_m1;

  logic [IW-1:0]        i_r, j_r, k_r, idx_d_r, root_r, u_r;
  logic [5:0]           uh_r;
  khd_pkg::op_t         op_d_r;
  logic [DIST_BITS-1:0] nearest_r, radius_r, thr_r, v_r;
  logic                 v_ok_r;
  logic [6:0]           cand_r, le_r;
  logic [CW-1:0]        head_r, tail_r;
  logic [LIM-1:0]       vis_r;

  logic [DIST_BITS-1:0] dmem [DDEPTH];
  logic                 amem [DDEPTH];
  logic [IW+5:0]        qmem [LIM];
  logic [5:0]           hmem [LIM];

  logic [DIST_BITS-1:0] d_q_r;
  logic                 a_q_r;
  logic [IW+5:0]        q_q_r;
  logic [5:0]           h_q_r;

  logic                 out_valid_r;
  logic [5:0]           tgt_r;
  logic [khd_pkg::HOP_W-1:0] hop_r;
  logic                 last_r;

  logic accept, ld_we, new_visit, q_we, adj_bit, d_near;
  logic [IW-1:0]  rd_col;
  logic [IW+5:0]  q_wd;
  logic [IW-1:0]  q_wa, h_wa;
  logic [5:0]     h_wd, hop_nx;
  logic           h_we;

  always_comb begin
    if (n_r == '0) n_act = 7'd1;
    else if (n_r > 7'(LIM)) n_act = 7'(LIM);
    else n_act = n_r;
  end
  assign n_m1 = n_act - 7'd1;

  assign accept = cmd.in_take && in_tvalid;
  assign ld_we  = accept && (in_tuser == khd_pkg::REQ_LOAD) &&
                  (7'(in_row) < 7'(LIM)) && (7'(in_col) < 7'(LIM));

  assign st.in_pending  = in_tvalid;
  assign st.is_query    = (in_tuser == khd_pkg::REQ_QUERY);
  assign st.q_ok        = 7'(in_row) < n_act;
  assign st.graph_ready = gready_r;
  assign st.i_last      = 7'(i_r) == n_m1;
  assign st.j_last      = 7'(j_r) == n_m1;
  assign st.k_last      = 7'(k_r) == n_m1;
  assign st.cand_gt     = cand_r > {1'b0, mc_r};
  assign st.q_empty     = head_r == tail_r;
  assign st.out_busy    = out_valid_r;

  assign rd_col    = (cmd.op == khd_pkg::OP_S_K) ? k_r : j_r;
  assign adj_bit   = (idx_d_r != i_r) && (d_q_r <= thr_r);
  assign d_near    = (idx_d_r != i_r) && (d_q_r <= radius_r);
  assign hop_nx    = (uh_r == khd_pkg::HOP_MAX) ? uh_r : uh_r + 6'd1;
  assign new_visit = (op_d_r == khd_pkg::OP_W_V) && a_q_r && !vis_r[idx_d_r];

  // walk writes: seed on init, discovered nodes afterwards
  always_comb begin
    if (cmd.op == khd_pkg::OP_W_INIT) begin
      q_we = 1'b1;
      q_wa = '0;
      q_wd = {6'd0, root_r};
      h_we = 1'b1;
      h_wa = root_r;
      h_wd = 6'd0;
    end else begin
      q_we = new_visit && (tail_r < CW'(LIM));
      q_wa = tail_r[IW-1:0];
      q_wd = {hop_nx, idx_d_r};
      h_we = new_visit;
      h_wa = idx_d_r;
      h_wd = hop_nx;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_we) dmem[{in_row[IW-1:0], in_col[IW-1:0]}] <= dv;
    d_q_r <= dmem[{i_r, rd_col}];
    if (op_d_r == khd_pkg::OP_A_RD) amem[{i_r, idx_d_r}] <= adj_bit;
    a_q_r <= amem[{u_r, j_r}];
    if (q_we) qmem[q_wa] <= q_wd;
    q_q_r <= qmem[head_r[IW-1:0]];
    if (h_we) hmem[h_wa] <= h_wd;
    h_q_r <= hmem[j_r];
  end

  // configuration and graph validity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r      <= 7'd64;
      mc_r     <= 6'd3;
      gready_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          khd_pkg::CFG_NODE_COUNT:   n_r  <= cfg_data;
          khd_pkg::CFG_MAX_CHILDREN: mc_r <= cfg_data[5:0];
          default: ;
        endcase
        gready_r <= 1'b0;
      end else if (ld_we) begin
        gready_r <= 1'b0;
      end else if (cmd.op == khd_pkg::OP_A_END && st.i_last) begin
        gready_r <= 1'b1;
      end
    end
  end

  // counters, accumulators and walk control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_d_r <= khd_pkg::OP_NOP;
      vis_r  <= '0;
      head_r <= '0;
      tail_r <= '0;
    end else begin
      op_d_r  <= cmd.op;
      idx_d_r <= rd_col;
      if (accept && (in_tuser == khd_pkg::REQ_QUERY)) root_r <= in_row[IW-1:0];

      case (cmd.op)
        khd_pkg::OP_B_INIT: begin
          radius_r <= '0;
          i_r      <= '0;
        end
        khd_pkg::OP_R_ROW: begin
          nearest_r <= '1;
          j_r       <= '0;
        end
        khd_pkg::OP_R_RD, khd_pkg::OP_C_RD, khd_pkg::OP_A_RD, khd_pkg::OP_W_V:
          j_r <= j_r + 1'b1;
        khd_pkg::OP_R_END: begin
          if (nearest_r > radius_r) radius_r <= nearest_r;
          i_r <= st.i_last ? '0 : i_r + 1'b1;
        end
        khd_pkg::OP_T_ROW: begin
          cand_r <= '0;
          thr_r  <= '1;
          j_r    <= '0;
        end
        khd_pkg::OP_C_END: j_r <= '0;
        khd_pkg::OP_S_RD: begin
          le_r <= '0;
          k_r  <= '0;
        end
        khd_pkg::OP_S_K: k_r <= k_r + 1'b1;
        khd_pkg::OP_S_JEND: begin
          if (v_ok_r && (le_r > {1'b0, mc_r}) && (v_r < thr_r)) thr_r <= v_r;
          j_r <= st.j_last ? '0 : j_r + 1'b1;
        end
        khd_pkg::OP_A_END: begin
          if (!st.i_last) i_r <= i_r + 1'b1;
          j_r <= '0;
        end
        khd_pkg::OP_W_INIT: begin
          vis_r  <= LIM'(1) << root_r;
          head_r <= '0;
          tail_r <= CW'(1);
        end
        khd_pkg::OP_W_POP: begin
          if (!st.q_empty) head_r <= head_r + 1'b1;
          j_r <= '0;
        end
        khd_pkg::OP_O_LD: if (!st.j_last) j_r <= j_r + 1'b1;
        default: ;
      endcase

      // work on data read in the previous cycle
      case (op_d_r)
        khd_pkg::OP_R_RD:
          if ((idx_d_r != i_r) && (d_q_r < nearest_r)) nearest_r <= d_q_r;
        khd_pkg::OP_C_RD: if (d_near) cand_r <= cand_r + 7'd1;
        khd_pkg::OP_S_RD: begin
          v_r    <= d_q_r;
          v_ok_r <= d_near;
        end
        khd_pkg::OP_S_K: if (d_near && (d_q_r <= v_r)) le_r <= le_r + 7'd1;
        khd_pkg::OP_W_POP: begin
          u_r  <= q_q_r[IW-1:0];
          uh_r <= q_q_r[IW+5:IW];
        end
        khd_pkg::OP_W_V: if (new_visit) begin
          vis_r[idx_d_r] <= 1'b1;
          if (q_we) tail_r <= tail_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == khd_pkg::OP_O_LD) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == khd_pkg::OP_O_LD) begin
      tgt_r  <= 6'(j_r);
      hop_r  <= vis_r[j_r] ? {1'b0, h_q_r} : khd_pkg::HOP_NONE;
      last_r <= st.j_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, hop_r, tgt_r};
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

### rtl/khd_ctrl.sv
// controller: sequences loading, graph building, walk and result output
`timescale 1ns / 1ps
`default_nettype none

module khd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire khd_pkg::status_t st,
  output khd_pkg::cmd_t         cmd
);

  typedef enum logic [24:0] {
    ST_IDLE   = 25'h0000001,
    ST_B_INIT = 25'h0000002,
    ST_R_ROW  = 25'h0000004,
    ST_R_RD   = 25'h0000008,
    ST_R_DRN  = 25'h0000010,
    ST_R_END  = 25'h0000020,
    ST_T_ROW  = 25'h0000040,
    ST_C_RD   = 25'h0000080,
    ST_C_DRN  = 25'h0000100,
    ST_C_END  = 25'h0000200,
    ST_S_RD   = 25'h0000400,
    ST_S_V    = 25'h0000800,
    ST_S_K    = 25'h0001000,
    ST_S_KDRN = 25'h0002000,
    ST_S_JEND = 25'h0004000,
    ST_A_RD   = 25'h0008000,
    ST_A_DRN  = 25'h0010000,
    ST_A_END  = 25'h0020000,
    ST_W_INIT = 25'h0040000,
    ST_W_POP  = 25'h0080000,
    ST_W_POPD = 25'h0100000,
    ST_W_V    = 25'h0200000,
    ST_W_DRN  = 25'h0400000,
    ST_O_RD   = 25'h0800000,
    ST_O_LD   = 25'h1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd.op      = khd_pkg::OP_NOP;
    cmd.in_take = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd.in_take = 1'b1;
        if (st.in_pending && st.is_query && st.q_ok)
          state_nxt = st.graph_ready ? ST_W_INIT : ST_B_INIT;
      end
      ST_B_INIT: begin cmd.op = khd_pkg::OP_B_INIT; state_nxt = ST_R_ROW; end
      ST_R_ROW:  begin cmd.op = khd_pkg::OP_R_ROW;  state_nxt = ST_R_RD; end
      ST_R_RD: begin
        cmd.op = khd_pkg::OP_R_RD;
        if (st.j_last) state_nxt = ST_R_DRN;
      end
      ST_R_DRN: state_nxt = ST_R_END;
      ST_R_END: begin
        cmd.op    = khd_pkg::OP_R_END;
        state_nxt = st.i_last ? ST_T_ROW : ST_R_ROW;
      end
      ST_T_ROW: begin cmd.op = khd_pkg::OP_T_ROW; state_nxt = ST_C_RD; end
      ST_C_RD: begin
        cmd.op = khd_pkg::OP_C_RD;
        if (st.j_last) state_nxt = ST_C_DRN;
      end
      ST_C_DRN: state_nxt = ST_C_END;
      ST_C_END: begin
        cmd.op    = khd_pkg::OP_C_END;
        state_nxt = st.cand_gt ? ST_S_RD : ST_A_RD;
      end
      ST_S_RD: begin cmd.op = khd_pkg::OP_S_RD; state_nxt = ST_S_V; end
      ST_S_V:  state_nxt = ST_S_K;
      ST_S_K: begin
        cmd.op = khd_pkg::OP_S_K;
        if (st.k_last) state_nxt = ST_S_KDRN;
      end
      ST_S_KDRN: state_nxt = ST_S_JEND;
      ST_S_JEND: begin
        cmd.op    = khd_pkg::OP_S_JEND;
        state_nxt = st.j_last ? ST_A_RD : ST_S_RD;
      end
      ST_A_RD: begin
        cmd.op = khd_pkg::OP_A_RD;
        if (st.j_last) state_nxt = ST_A_DRN;
      end
      ST_A_DRN: state_nxt = ST_A_END;
      ST_A_END: begin
        cmd.op    = khd_pkg::OP_A_END;
        state_nxt = st.i_last ? ST_W_INIT : ST_T_ROW;
      end
      ST_W_INIT: begin cmd.op = khd_pkg::OP_W_INIT; state_nxt = ST_W_POP; end
      ST_W_POP: begin
        cmd.op    = khd_pkg::OP_W_POP;
        state_nxt = st.q_empty ? ST_O_RD : ST_W_POPD;
      end
      ST_W_POPD: state_nxt = ST_W_V;
      ST_W_V: begin
        cmd.op = khd_pkg::OP_W_V;
        if (st.j_last) state_nxt = ST_W_DRN;
      end
      ST_W_DRN: state_nxt = ST_W_POP;
      ST_O_RD: begin
        if (!st.out_busy) begin
          cmd.op    = khd_pkg::OP_O_RD;
          state_nxt = ST_O_LD;
        end
      end
      ST_O_LD: begin
        cmd.op    = khd_pkg::OP_O_LD;
        state_nxt = st.j_last ? ST_IDLE : ST_O_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

`default_nettype wire

### rtl/knn_graph_hop_distance_unit.sv
// top level of the neighbourhood graph hop distance unit
`timescale 1ns / 1ps
`default_nettype none

// Loads a pairwise distance matrix one item at a time and answers row queries
// with breadth-first hop counts over a neighbourhood graph. While idle, load
// items are taken back to back. The first query after any load or register
// write first builds the graph from the distance memory: a radius pass over
// all rows, then per row candidate counting and, where trimming applies, rank
// selection, then a write of the adjacency row, all paced by the single read
// port of the distance memory. Each query then walks the adjacency memory,
// paced by the one-bit-a-cycle adjacency read, and then emits one result
// item per node, waiting while the output register is still full. A query
// on a row outside the node count is taken and gives no items. The input is
// accepted only while the unit is idle; a result left in the output register
// does not stop the next input item from being taken.
module knn_graph_hop_distance_unit #(
  parameter int MAX_NODES = 64,
  parameter int DIST_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // row_index[5:0], col_index[11:6], dist_value[43:12]
  input  wire logic        in_tuser,   // req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // target_node[5:0], hop_count[12:6]
  output logic             out_tlast,  // last_of_row
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,  // 0 node_count, 1 max_children
  input  wire logic [6:0]  cfg_data
);

  khd_pkg::cmd_t    cmd;
  khd_pkg::status_t st;

  // controller only steps the sequence; all storage sits in the datapath
  khd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  khd_datapath #(
    .MAX_NODES (MAX_NODES),
    .DIST_BITS (DIST_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // ready only in the idle state of the sequence
  assign in_tready = cmd.in_take;

endmodule

`default_nettype wire

### rtl/khd_checker.sv
// port checker for the hop distance unit and its bind
`timescale 1ns / 1ps
`default_nettype none

`include "knn_graph_hop_distance_unit_assert.svh"

module khd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tlast
);

  // a stalled item holds its value
  `KHD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))
  // hop count is unreachable or in range
  `KHD_ASSERT_NOW(a_hop_range, clk, rst_n, out_tvalid, !out_tdata[12] || (out_tdata[12:6] == 7'h7F))
  // idle after reset
  `KHD_ASSERT_NEXT(a_rst_ready, clk, 1'b1, !rst_n, in_tready)
  // padding above the hop count stays clear
  `KHD_ASSERT_NOW(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[15:13] == 3'd0)

endmodule

bind knn_graph_hop_distance_unit khd_checker u_chk (.*);

`default_nettype wire
